/* rtl/wsd_pkg.sv */
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int JOB_W   = 64;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int SIZE_W  = 3;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [JOB_W-1:0] job_data;
    } t_wsd_in;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [JOB_W-1:0]   job_out;
        logic [COUNT_W-1:0] count;
    } t_wsd_out;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the accepted operation
        logic exec;   // update indexes, write or read the job slot
    } t_wsd_cmd;

endpackage

/* rtl/wsd_ctrl.sv */
`timescale 1ns / 1ps

module wsd_ctrl
    import wsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_done,
    output t_wsd_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
        n_done = (n_state == S_RESP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_cmd.load = start && !r_busy;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

/* rtl/wsd_datapath.sv */
`timescale 1ns / 1ps

module wsd_datapath
    import wsd_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int JOB_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wsd_cmd          i_cmd,
    input  t_wsd_in           i_item,
    input  logic              i_cfg_wr,
    input  logic [SIZE_W-1:0] i_cfg_size_log2,
    output t_wsd_out          o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = AW + 1;   // indexes run modulo 2*DEPTH

    logic [JOB_WIDTH-1:0] mem [DEPTH];

    logic [OP_W-1:0]      r_op;
    logic [JOB_WIDTH-1:0] r_data;
    logic [IW-1:0]        r_top, n_top;
    logic [IW-1:0]        r_bot, n_bot;
    logic [SIZE_W-1:0]    r_size_log2;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [IW-1:0]        r_count;
    logic                 r_take, n_take;
    logic [JOB_WIDTH-1:0] r_rd_data;

    logic [IW-1:0] held;
    logic [IW-1:0] cap;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;

    always_comb begin
        held = r_bot - r_top;
        if (32'(r_size_log2) >= AW) begin
            cap = IW'(DEPTH);
        end else begin
            cap = IW'(1) << r_size_log2;
        end
    end

    always_comb begin
        n_top    = r_top;
        n_bot    = r_bot;
        n_status = ST_OK;
        n_take   = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = r_bot[AW-1:0];
        rd_addr  = r_top[AW-1:0];
        case (r_op)
            OP_PUSH: begin
                if (held >= cap) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    n_bot = r_bot + IW'(1);
                end
            end
            OP_POP: begin
                if (held == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_bot   = r_bot - IW'(1);
                    rd_addr = n_bot[AW-1:0];
                    rd_en   = 1'b1;
                    n_take  = 1'b1;
                end
            end
            OP_STEAL: begin
                if (held == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_top  = r_top + IW'(1);
                    rd_en  = 1'b1;
                    n_take = 1'b1;
                end
            end
            default: ;   // unknown op leaves the indexes and job slots as is
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_bot       <= '0;
            r_size_log2 <= SIZE_LOG2_RESET;
        end else begin
            if (i_cfg_wr) begin
                r_size_log2 <= i_cfg_size_log2;
            end
            if (i_cmd.exec) begin
                r_top <= n_top;
                r_bot <= n_bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.op;
            r_data <= i_item.job_data[JOB_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_take   <= n_take;
            r_count  <= n_bot - n_top;
        end
    end

    // job slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_data;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_result.status  = r_status;
    assign o_result.job_out = r_take ? JOB_W'(r_rd_data) : '0;
    assign o_result.count   = COUNT_W'(r_count);

endmodule

/* rtl/work_stealing_deque.sv */
`timescale 1ns / 1ps

// Work-stealing deque core: a ring buffer of job words with push and pop at
// the bottom end and steal at the top end.
// Command channel: drive i_cmd (op, job_data) with start; the operation is
// taken at a rising edge where start is high and busy is low.
// Result channel: o_result (status, job_out, count) is valid for exactly one
// cycle while o_done is high. There is no backpressure; the receiver must
// take it in that cycle.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_size_log2 sets the
// capacity (2**size_log2, saturating at DEPTH). Write only while idle.
// Timing: o_done rises at the edge after the accepting edge. busy stays high
// until the result has been taken, so no new operation is taken before the
// controller has walked capture, execute (index update and registered slot
// read) and respond.
// Reset (synchronous, active low) empties the deque and sets size_log2 to 6.
// Slot contents are not cleared; only slots between top and bottom are read.
module work_stealing_deque_core
    import wsd_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int JOB_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_wsd_in           i_cmd,
    output logic              o_done,
    output t_wsd_out          o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_size_log2
);

    t_wsd_cmd cmd;

    assign o_cfg_ready = 1'b1;

    wsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    wsd_datapath #(
        .DEPTH     (DEPTH),
        .JOB_WIDTH (JOB_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_item          (i_cmd),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_size_log2 (i_cfg_size_log2),
        .o_result        (o_result)
    );

endmodule

/* bench/tb_work_stealing_deque_core.sv */
`timescale 1ns / 1ps

module tb_work_stealing_deque_core;
    import wsd_pkg::*;

    localparam int DEPTH     = 64;
    localparam int JOB_WIDTH = 64;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // undefined op: no state change
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 112;

    // Tracks deque contents and holds the results each accepted op should produce.
    class job_deque_tracker;
        logic [JOB_W-1:0]   slots [DEPTH];
        logic [COUNT_W-1:0] top_idx;
        logic [COUNT_W-1:0] bot_idx;
        logic [SIZE_W-1:0]  size_log2;
        t_wsd_out           pending_results [$];
        int mismatches;
        int ops_seen;
        int results_seen;
        int full_seen;
        int empty_seen;

        function new();
            top_idx      = '0;
            bot_idx      = '0;
            size_log2    = SIZE_LOG2_RESET;
            mismatches   = 0;
            ops_seen     = 0;
            results_seen = 0;
            full_seen    = 0;
            empty_seen   = 0;
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_log2 = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function t_wsd_out apply_op(t_wsd_in cmd);
            t_wsd_out           r;
            logic [COUNT_W-1:0] held;
            int                 cap;
            held = bot_idx - top_idx;
            cap  = 1 << size_log2;
            if (cap > DEPTH) cap = DEPTH;
            r.status  = ST_OK;
            r.job_out = '0;
            case (cmd.op)
                OP_PUSH: begin
                    if (held >= cap) begin
                        r.status = ST_FULL;
                    end else begin
                        slots[bot_idx[SLOT_W-1:0]] = cmd.job_data;
                        bot_idx = bot_idx + 1'b1;
                    end
                end
                OP_POP: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        bot_idx   = bot_idx - 1'b1;
                        r.job_out = slots[bot_idx[SLOT_W-1:0]];
                    end
                end
                OP_STEAL: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.job_out = slots[top_idx[SLOT_W-1:0]];
                        top_idx   = top_idx + 1'b1;
                    end
                end
                default: ;
            endcase
            r.count = bot_idx - top_idx;
            return r;
        endfunction

        function void note_operation(t_wsd_in cmd);
            t_wsd_out r;
            r = apply_op(cmd);
            ops_seen++;
            if (r.status == ST_FULL) full_seen++;
            if (r.status == ST_EMPTY) empty_seen++;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_wsd_out got);
            t_wsd_out want;
            if (pending_results.size() == 0) begin
                report_mismatch("result strobe with no operation outstanding");
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              got.status, want.status));
                if (got.job_out !== want.job_out)
                    report_mismatch($sformatf("job_out got %h want %h",
                                              got.job_out, want.job_out));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              got.count, want.count));
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_wsd_in           i_cmd;
    logic              o_done;
    t_wsd_out          o_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_size_log2;

    job_deque_tracker tracker;
    bit               no_idle;
    int               cfg_writes;

    work_stealing_deque_core #(
        .DEPTH    (DEPTH),
        .JOB_WIDTH(JOB_WIDTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_done         (o_done),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_size_log2(i_cfg_size_log2)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_result(o_result);
    end

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [JOB_W-1:0] pick_job();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function logic [OP_W-1:0] pick_op(int push_pct);
        if ($urandom_range(0, 99) < 3) return OP_NONE;
        if ($urandom_range(0, 99) < push_pct) return OP_PUSH;
        return $urandom_range(0, 1) ? OP_POP : OP_STEAL;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with start still high so a following op can go back to back.
    task drive_op(logic [OP_W-1:0] op, logic [JOB_W-1:0] data, int gap);
        t_wsd_in cmd;
        cmd.op       = op;
        cmd.job_data = data;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = cmd;
        do @(posedge i_clk); while (busy);
        tracker.note_operation(cmd);
        @(negedge i_clk);
    endtask

    // Capacity writes only once every outstanding result has come back.
    task write_size(logic [SIZE_W-1:0] v);
        start = 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid     = 1'b1;
        i_cfg_size_log2 = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_size(v);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int               push_pct;
        int               guard;
        logic [SIZE_W-1:0] sz;
        tracker         = new();
        cfg_writes      = 0;
        no_idle         = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_size_log2 = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty deque, undefined op, both ends, extreme job words
        drive_op(OP_POP,   '0, 0);
        drive_op(OP_STEAL, '1, 0);
        drive_op(OP_NONE,  '1, 1);
        drive_op(OP_PUSH,  '0, 0);
        drive_op(OP_PUSH,  '1, 2);
        drive_op(OP_PUSH,  64'h0123_4567_89ab_cdef, 0);
        drive_op(OP_NONE,  64'h5555_aaaa_5555_aaaa, 0);
        drive_op(OP_STEAL, '0, 0);
        drive_op(OP_POP,   '0, 3);
        drive_op(OP_POP,   '0, 0);
        drive_op(OP_POP,   '0, 0);

        // capacity of one
        write_size(3'd0);
        drive_op(OP_PUSH,  64'hdead_beef_0000_0001, 0);
        drive_op(OP_PUSH,  64'hdead_beef_0000_0002, 0);
        drive_op(OP_STEAL, '0, 0);
        drive_op(OP_STEAL, '0, 0);

        // request above DEPTH saturates
        write_size(3'd7);
        repeat (5) drive_op(OP_PUSH, pick_job(), 0);

        // capacity shrunk below the held count
        write_size(3'd1);
        drive_op(OP_PUSH,  pick_job(), 0);
        drive_op(OP_POP,   '0, 0);
        drive_op(OP_STEAL, '0, 0);
        drive_op(OP_PUSH,  pick_job(), 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       sz = 3'd6;
                1:       sz = 3'd0;
                2:       sz = 3'd1;
                3:       sz = 3'd7;
                4:       sz = 3'd2;
                5:       sz = 3'd5;
                6:       sz = 3'd3;
                7:       sz = 3'd4;
                default: sz = $urandom_range(0, 7);
            endcase
            write_size(sz);
            no_idle = ($urandom_range(0, 2) == 0);
            push_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // swing between filling and draining so both ends hit their limits
                if (n % 28 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 20;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                drive_op(pick_op(push_pct), pick_job(), pick_gap());
            end
        end
        start = 1'b0;

        guard = 0;
        while (tracker.pending() > 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (5) @(posedge i_clk);
        if (tracker.pending() > 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending()));

        $display("ran %0d deque operations over %0d capacity settings, %0d results checked",
                 tracker.ops_seen, cfg_writes, tracker.results_seen);
        $display("answers included %0d full and %0d empty, %0d mismatches",
                 tracker.full_seen, tracker.empty_seen, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("PASS work_stealing_deque_core");
        end else begin
            $display("FAIL work_stealing_deque_core");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL work_stealing_deque_core");
        $finish;
    end

endmodule
